[sv/lsfe_pkg.sv]
// shared types and constants for the led strip frame encoder
// no dependencies
package lsfe_pkg;

	localparam int unsigned START_BYTES = 4;
	localparam int unsigned PIXEL_BYTES = 4;
	localparam logic [7:0] START_FILL  = 8'h00;
	localparam logic [7:0] END_FILL    = 8'hFF;
	localparam logic [7:0] HEADER_RST  = 8'hFF;

	// byte positions inside a pixel
	localparam logic [1:0] POS_HEADER = 2'd0;
	localparam logic [1:0] POS_BLUE   = 2'd1;
	localparam logic [1:0] POS_GREEN  = 2'd2;
	localparam logic [1:0] POS_RED    = 2'd3;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_done;
	} strip_word_t;

	// one queued pixel plus what the front decided about it
	typedef struct packed {
		pixel_t px;
		logic   start;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		PH_ENTRY,
		PH_START,
		PH_PIXEL,
		PH_END
	} phase_t;

endpackage

[sv/lsfe_front.sv]
// front end: accepts pixels, tracks whether a frame is open, tags start of frame
// depends on lsfe_pkg
module lsfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  lsfe_pkg::pixel_t  pix,
	input  lsfe_pkg::q_status_t q_status,
	output logic              push,
	output lsfe_pkg::qent_t   push_ent
);
	import lsfe_pkg::*;

	logic frame_open_q;

	assign pix_stall = q_status.full;
	assign push      = pix_valid && !q_status.full;

	always_comb begin
		push_ent.px    = pix;
		push_ent.start = !frame_open_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (push) begin
			frame_open_q <= !pix.last_pixel;
		end
	end

endmodule

[sv/lsfe_queue.sv]
// two-entry queue between front and back
// depends on lsfe_pkg
module lsfe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lsfe_pkg::qent_t     push_ent,
	input  logic                pop,
	output lsfe_pkg::qent_t     head,
	output lsfe_pkg::q_status_t status
);
	import lsfe_pkg::*;

	qent_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head         = ent_q[rd_ptr_q];
	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/lsfe_back.sv]
// back end: byte sequencer over start frame, pixel and end frame, with output register
// depends on lsfe_pkg
module lsfe_back #(
	parameter int unsigned END_BYTES = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsfe_pkg::qent_t       head,
	input  lsfe_pkg::q_status_t   q_status,
	input  logic [7:0]            header_byte,
	output logic                  pop,
	output logic                  strip_valid,
	input  logic                  strip_stall,
	output lsfe_pkg::strip_word_t strip
);
	import lsfe_pkg::*;

	localparam int unsigned CNT_W = $clog2(END_BYTES);

	phase_t      phase_q, phase_nxt, cur_ph;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic        advance, fire, done;
	strip_word_t gen;
	logic        out_valid_q;
	strip_word_t out_word_q;

	assign advance = !out_valid_q || !strip_stall;
	assign fire    = advance && !q_status.empty;
	assign pop     = fire && done;

	assign strip_valid = out_valid_q;
	assign strip       = out_word_q;

	// phase of the byte about to go out
	always_comb begin
		cur_ph = phase_q;
		if (phase_q == PH_ENTRY) begin
			cur_ph = head.start ? PH_START : PH_PIXEL;
		end
	end

	// next state
	always_comb begin
		phase_nxt = phase_q;
		cnt_nxt   = cnt_q;
		if (fire) begin
			cnt_nxt   = cnt_q + CNT_W'(1);
			phase_nxt = cur_ph;
			case (cur_ph)
				PH_START: begin
					if (cnt_q == CNT_W'(START_BYTES - 1)) begin
						phase_nxt = PH_PIXEL;
						cnt_nxt   = '0;
					end
				end
				PH_PIXEL: begin
					if (cnt_q == CNT_W'(PIXEL_BYTES - 1)) begin
						phase_nxt = head.px.last_pixel ? PH_END : PH_ENTRY;
						cnt_nxt   = '0;
					end
				end
				PH_END: begin
					if (cnt_q == CNT_W'(END_BYTES - 1)) begin
						phase_nxt = PH_ENTRY;
						cnt_nxt   = '0;
					end
				end
				default: begin
					phase_nxt = PH_ENTRY;
					cnt_nxt   = '0;
				end
			endcase
		end
	end

	// outputs: generated byte and end-of-item flag
	always_comb begin
		gen  = '0;
		done = 1'b0;
		case (cur_ph)
			PH_START: gen.out_byte = START_FILL;
			PH_PIXEL: begin
				case (cnt_q[1:0])
					POS_HEADER: gen.out_byte = header_byte;
					POS_BLUE:   gen.out_byte = head.px.blue;
					POS_GREEN:  gen.out_byte = head.px.green;
					POS_RED:    gen.out_byte = head.px.red;
					default:    gen.out_byte = head.px.red;
				endcase
				if (cnt_q == CNT_W'(PIXEL_BYTES - 1) && !head.px.last_pixel) begin
					done         = 1'b1;
					gen.run_last = 1'b1;
				end
			end
			PH_END: begin
				gen.out_byte = END_FILL;
				if (cnt_q == CNT_W'(END_BYTES - 1)) begin
					done           = 1'b1;
					gen.run_last   = 1'b1;
					gen.frame_done = 1'b1;
				end
			end
			default: gen.out_byte = START_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ENTRY;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
			if (advance) begin
				out_valid_q <= !q_status.empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_word_q <= gen;
		end
	end

endmodule

[sv/led_strip_frame_encoder.sv]
// top level of the led strip frame encoder: header register, front, queue, back
// depends on lsfe_pkg, lsfe_front, lsfe_queue, lsfe_back
//
// usage
// - pixel channel (pix_valid / pix_stall / pix): one word per pixel carrying
//   blue, green, red and last_pixel; a word is taken when pix_valid is high
//   and pix_stall is low
// - strip channel (strip_valid / strip_stall / strip): one word per byte in
//   wire order; run_last marks the final byte of a pixel not marked last
//   and the final byte of the end frame, which frame_done also marks
// - cfg channel (cfg_valid / cfg_ready / cfg_data): writes header_byte, which
//   leads every pixel; write only while the block is idle; cfg_ready is
//   always high
// - a pixel that opens a frame is preceded by four zero bytes; a pixel marked
//   last is followed by END_BYTES bytes of 0xff
// - on an empty block, a taken pixel is written into the queue and its first
//   byte then goes out through the output register
// - the back-end sequencer sends one byte per cycle while a pixel is queued and the
//   receiver does not stall: 4 bytes per pixel, plus 4 for a frame start and END_BYTES for a frame end
// - a two-entry queue lets the front take pixels while the back is busy;
//   pix_stall rises only when that queue is full
// - when the receiver stalls, the output register holds its word and the
//   sequencer waits; nothing is lost
// - reset clears the queue, closes the frame and sets header_byte to 0xff
module led_strip_frame_encoder #(
	parameter int unsigned END_BYTES = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  lsfe_pkg::pixel_t      pix,
	output logic                  strip_valid,
	input  logic                  strip_stall,
	output lsfe_pkg::strip_word_t strip,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data
);
	import lsfe_pkg::*;

	logic       header_we;
	logic [7:0] header_byte_q;
	logic       push, pop;
	qent_t      push_ent, head;
	q_status_t  q_status;

	// config is always accepted
	assign cfg_ready = 1'b1;
	assign header_we = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q <= HEADER_RST;
		end else if (header_we) begin
			header_byte_q <= cfg_data;
		end
	end

	// front: takes pixels, tags the first pixel of each frame
	lsfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.q_status (q_status),
		.push     (push),
		.push_ent (push_ent)
	);

	// decoupling queue
	lsfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ent(push_ent),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	// back: one byte per cycle from the queue head while a pixel is queued and the receiver does not stall
	lsfe_back #(
		.END_BYTES(END_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.header_byte(header_byte_q),
		.pop        (pop),
		.strip_valid(strip_valid),
		.strip_stall(strip_stall),
		.strip      (strip)
	);

endmodule

[sv/lsfe_checker.sv]
// port-level checker for the led strip frame encoder, bound to the top level
// depends on lsfe_pkg and led_strip_frame_encoder
module lsfe_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  strip_valid,
	input logic                  strip_stall,
	input lsfe_pkg::strip_word_t strip
);
	import lsfe_pkg::*;

	logic acc;
	logic expect_start_q;

	assign acc = strip_valid && !strip_stall;

	// after an end frame the next byte must begin a start frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_start_q <= 1'b1;
		end else if (acc) begin
			expect_start_q <= strip.frame_done;
		end
	end

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && strip.frame_done |-> strip.run_last)
		else $error("frame_done without run_last");

	a_done_is_ff: assert property (@(posedge clk) disable iff (!arst_n)
		acc && strip.frame_done |-> strip.out_byte == END_FILL)
		else $error("end frame byte is not 0xff");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && expect_start_q |-> strip.out_byte == START_FILL && !strip.run_last)
		else $error("frame does not open with a start byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		strip_valid && strip_stall |=> strip_valid && $stable(strip))
		else $error("stalled strip word changed");

endmodule

bind led_strip_frame_encoder lsfe_checker u_lsfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.strip_valid(strip_valid),
	.strip_stall(strip_stall),
	.strip      (strip)
);

[tb/strip_byte_checker.sv]
// checker for the led strip frame encoder: watches the pixel, strip and cfg channels,
// predicts every strip word and compares field by field
// depends on lsfe_pkg
module strip_byte_checker #(
	parameter int unsigned END_BYTES = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	input  logic                  pix_stall,
	input  lsfe_pkg::pixel_t      pix,
	input  logic                  strip_valid,
	input  logic                  strip_stall,
	input  lsfe_pkg::strip_word_t strip,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [7:0]            cfg_data,
	output int unsigned           fail_count,
	output int unsigned           pending,
	output int unsigned           word_count,
	output int unsigned           frame_count
);
	import lsfe_pkg::*;

	strip_word_t bytes_due[$];
	logic [7:0]  header_now;
	logic        frame_open_now;
	int unsigned fails = 0;
	int unsigned due_count = 0;
	int unsigned words_seen = 0;
	int unsigned frames_seen = 0;

	assign fail_count  = fails;
	assign pending     = due_count;
	assign word_count  = words_seen;
	assign frame_count = frames_seen;

	function automatic void queue_byte(input logic [7:0] b, input logic run_end,
			input logic frame_end);
		strip_word_t w;
		w.out_byte   = b;
		w.run_last   = run_end;
		w.frame_done = frame_end;
		bytes_due.push_back(w);
	endfunction

	// all words that one pixel causes, in wire order
	function automatic void encode_pixel(input pixel_t p);
		if (!frame_open_now) begin
			for (int i = 0; i < START_BYTES; i++)
				queue_byte(START_FILL, 1'b0, 1'b0);
			frame_open_now = 1'b1;
		end
		queue_byte(header_now, 1'b0, 1'b0);
		queue_byte(p.blue, 1'b0, 1'b0);
		queue_byte(p.green, 1'b0, 1'b0);
		if (p.last_pixel) begin
			queue_byte(p.red, 1'b0, 1'b0);
			for (int i = 0; i < END_BYTES - 1; i++)
				queue_byte(END_FILL, 1'b0, 1'b0);
			queue_byte(END_FILL, 1'b1, 1'b1);
			frame_open_now = 1'b0;
		end else begin
			queue_byte(p.red, 1'b1, 1'b0);
		end
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		strip_word_t want;
		if (!arst_n) begin
			header_now     = HEADER_RST;
			frame_open_now = 1'b0;
			bytes_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				header_now = cfg_data;
			// compare before queueing: a pixel taken now cannot show up this cycle
			if (strip_valid && !strip_stall) begin
				words_seen++;
				if (bytes_due.size() == 0) begin
					$error("strip word %0h with no word expected", strip);
					fails++;
				end else begin
					want = bytes_due.pop_front();
					check_field("out_byte", want.out_byte, strip.out_byte);
					check_field("run_last", want.run_last, strip.run_last);
					check_field("frame_done", want.frame_done, strip.frame_done);
					if (strip.frame_done)
						frames_seen++;
				end
			end
			if (pix_valid && !pix_stall)
				encode_pixel(pix);
		end
		due_count = bytes_due.size();
	end

endmodule

[tb/testbench.sv]
// testbench top for the led strip frame encoder: clock, reset, stimulus and verdict
// depends on lsfe_pkg, led_strip_frame_encoder and strip_byte_checker
module testbench;

	import lsfe_pkg::*;

	localparam int unsigned END_BYTES   = 12;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned BLOCKS      = 4;
	localparam int unsigned BLOCK_WORDS = 32;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        pix_valid   = 1'b0;
	logic        pix_stall;
	pixel_t      pix         = '0;
	logic        strip_valid;
	logic        strip_stall = 1'b0;
	strip_word_t strip;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data    = 8'h00;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned word_count;
	int unsigned frame_count;

	// chance in a hundred that a side idles on a given cycle
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycles        = 0;
	int unsigned pixels_sent   = 0;
	int unsigned header_writes = 0;
	// pixels still to go in the current random string
	int unsigned string_left   = 0;

	led_strip_frame_encoder #(
		.END_BYTES(END_BYTES)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix),
		.strip_valid(strip_valid),
		.strip_stall(strip_stall),
		.strip      (strip),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	strip_byte_checker #(
		.END_BYTES(END_BYTES)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix),
		.strip_valid(strip_valid),
		.strip_stall(strip_stall),
		.strip      (strip),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.word_count (word_count),
		.frame_count(frame_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls at random, at the rate of the current phase
	always @(posedge clk) begin
		strip_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	// offer one pixel word and hold it until taken; called and returns on a rising edge
	task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic last);
		pixel_t p;
		p.blue       = b;
		p.green      = g;
		p.red        = r;
		p.last_pixel = last;
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (pix_stall);
		pixels_sent++;
	endtask

	// drop valid and wait until every predicted word has come out
	task automatic drain;
		pix_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// header writes only happen with the block idle
	task automatic write_header(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		header_writes++;
	endtask

	// random color byte with the extremes weighted up
	function automatic logic [7:0] pick_byte;
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		logic [7:0] hdr;
		logic       last;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling, header still at its reset value
		// single-pixel strings: start, pixel and end frame from one word
		push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		// three-pixel string, the first two pixels with alternating bit patterns
		push_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
		push_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
		push_pixel(8'h01, 8'h80, 8'h7F, 1'b1);
		drain();
		write_header(8'h00);
		push_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
		drain();
		write_header(8'hE5);
		push_pixel(8'h12, 8'h34, 8'h56, 1'b0);
		push_pixel(8'hFE, 8'hEF, 8'h00, 1'b0);
		push_pixel(8'h80, 8'h01, 8'hC3, 1'b0);
		push_pixel(8'h3C, 8'h5A, 8'h96, 1'b1);
		drain();
		write_header(8'h80);
		push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		drain();
		// header change in the middle of an open frame: no new start frame after it
		write_header(8'h9F);
		push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
		push_pixel(8'h0F, 8'hF0, 8'h81, 1'b1);
		drain();
		write_header(8'hFF);

		// random part: three idling phases, each a run of blocks, each block with its own header
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < BLOCKS; blk++) begin
				drain();
				case ($urandom_range(3))
					0:       hdr = 8'hFF;
					1:       hdr = 8'h00;
					2:       hdr = 8'hE0 | 8'($urandom_range(31));
					default: hdr = 8'($urandom);
				endcase
				write_header(hdr);
				// strings run on across block edges, so frames stay open over header writes
				for (int n = 0; n < BLOCK_WORDS; n++) begin
					if (string_left == 0)
						string_left = ($urandom_range(7) == 0) ? $urandom_range(20, 7)
							: $urandom_range(6, 1);
					last = (string_left == 1);
					string_left--;
					push_pixel(pick_byte(), pick_byte(), pick_byte(), last);
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("sent %0d pixel words over %0d header settings", pixels_sent, header_writes);
		$display("checked %0d strip words, %0d end frames closed", word_count, frame_count);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/lsfe_pkg.sv
sv/lsfe_front.sv
sv/lsfe_queue.sv
sv/lsfe_back.sv
sv/led_strip_frame_encoder.sv
sv/lsfe_checker.sv
tb/strip_byte_checker.sv
tb/testbench.sv
